// ----- rtl/bcn_pkg.sv -----
`timescale 1ns / 1ps

package bcn_pkg;

  // block_format codes
  localparam logic [2:0] FMT_BC1 = 3'd0;
  localparam logic [2:0] FMT_BC2 = 3'd1;
  localparam logic [2:0] FMT_BC3 = 3'd2;
  localparam logic [2:0] FMT_BC4 = 3'd3;
  localparam logic [2:0] FMT_BC5 = 3'd4;

  // index of the final pixel of a block
  localparam logic [3:0] LAST_PIX = 4'd15;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef rgba_t [3:0] cpal_t;

  // 8-entry alpha palette, entry 0 in bits 7:0
  typedef logic [7:0][7:0] apal_t;

  // alpha endpoints plus the six weighted sums ahead of the divide
  typedef struct packed {
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             gt;
    logic [5:0][10:0] sum;
  } asum_t;

  // v*255/31, truncated: reciprocal multiply, exact for all 5-bit v
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] x;
    logic [28:0] p;
    x = {v, 8'd0} - 13'(v);
    p = 29'(x) * 29'd33826;
    return p[27:20];
  endfunction

  // v*255/63, truncated
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] x;
    logic [29:0] p;
    x = {v, 8'd0} - 14'(v);
    p = 30'(x) * 30'd16645;
    return p[27:20];
  endfunction

  // x/3 for x up to 766
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd5462;
    return p[21:14];
  endfunction

  // x/5 for x up to 1277
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  // x/7 for x up to 1788
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  // weighted endpoint sums with rounding bias, per alpha palette mode
  function automatic asum_t alpha_sums(input logic [7:0] a0, input logic [7:0] a1);
    asum_t s;
    s.a0 = a0;
    s.a1 = a1;
    s.gt = (a0 > a1);
    for (int k = 0; k < 6; k++) begin
      if (s.gt) begin
        s.sum[k] = 11'(6 - k) * 11'(a0) + 11'(k + 1) * 11'(a1) + 11'd3;
      end else if (k < 4) begin
        s.sum[k] = 11'(4 - k) * 11'(a0) + 11'(k + 1) * 11'(a1) + 11'd2;
      end else begin
        s.sum[k] = 11'd0;
      end
    end
    return s;
  endfunction

endpackage

// ----- rtl/bcn_if.sv -----
`timescale 1ns / 1ps

// compressed block channel
interface bcn_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;

  modport source (output valid, output block_low, output block_high, input ready);
  modport sink   (input valid, input block_low, input block_high, output ready);
endinterface

// decoded pixel channel
interface bcn_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [3:0] pixel_index;
  logic       last_pixel;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output pixel_index, output last_pixel, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input pixel_index, input last_pixel, output ready);
endinterface

// format register write channel
interface bcn_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] block_format;

  modport source (output valid, output block_format, input ready);
  modport sink   (input valid, input block_format, output ready);
endinterface

// ----- rtl/bcn_alpha_pal.sv -----
`timescale 1ns / 1ps

// Alpha palette from registered endpoint sums: divide by 7 or by 5,
// with the fixed 0 / 255 entries in the five-step mode.
module bcn_alpha_pal (
  input  bcn_pkg::asum_t sums_i,
  output bcn_pkg::apal_t pal_o
);
  import bcn_pkg::*;

  always_comb begin
    pal_o[0] = sums_i.a0;
    pal_o[1] = sums_i.a1;
    for (int k = 0; k < 6; k++) begin
      if (sums_i.gt) begin
        pal_o[k + 2] = div7(sums_i.sum[k]);
      end else if (k < 4) begin
        pal_o[k + 2] = div5(sums_i.sum[k]);
      end else if (k == 4) begin
        pal_o[k + 2] = 8'h00;
      end else begin
        pal_o[k + 2] = 8'hFF;
      end
    end
  end

endmodule

// ----- rtl/bcn_texture_block_decoder_unit.sv -----
`timescale 1ns / 1ps

// BC1..BC5 texture block decoder.
// in_blk takes one 4x4 block per word (bytes 0-7 on block_low, 8-15 on
// block_high, little endian). out_pix returns the 16 pixels as straight
// RGBA8 in raster order, tagged with pixel_index and last_pixel.
// cfg_wr writes block_format (0 BC1 .. 4 BC5, other codes give black
// transparent pixels); write it only while no block is in flight.
// cfg_wr.ready is always high.
// Pixel 0 reaches out_pix through the input register, the endpoint/sum
// stage, the palette stage and the output register.
// Throughput: one pixel per cycle while out_pix.ready is high; the
// pixel emission from the palette register sets the block rate.
// The next block is taken and decoded while the current one is emitted.
// When out_pix.ready is low the output word holds and the pipeline
// stalls behind it; in_blk.ready drops once all stages are full.
// Reset (rst_n low, synchronous) empties the pipeline and sets
// block_format to BC1.
module bcn_texture_block_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  bcn_cfg_if.sink    cfg_wr,
  bcn_blk_if.sink    in_blk,
  bcn_pix_if.source  out_pix
);
  import bcn_pkg::*;

  // format register
  logic [2:0] fmt_r;

  // stage 0: input register
  logic        s0_v_r;
  logic [63:0] s0_lo_r, s0_hi_r;

  // stage 1: expanded endpoints and alpha sums
  logic        s1_v_r;
  rgba_t       s1_ep0_r, s1_ep1_r, s1_ep0_nxt, s1_ep1_nxt;
  logic        s1_three_r, s1_three_nxt;
  logic [31:0] s1_csel_r;
  logic [47:0] s1_asel_lo_r, s1_asel_hi_r;
  logic [63:0] s1_ex_r;
  asum_t       s1_asum_lo_r, s1_asum_hi_r;

  // stage 2: palettes and per-pixel selectors, shifted as pixels go out
  logic        s2_v_r;
  logic [3:0]  s2_cnt_r;
  cpal_t       s2_cpal_r, s2_cpal_nxt;
  apal_t       s2_apal_lo_r, s2_apal_hi_r, s2_apal_lo_nxt, s2_apal_hi_nxt;
  logic [31:0] s2_csel_r;
  logic [47:0] s2_asel_lo_r, s2_asel_hi_r;
  logic [63:0] s2_ex_r;

  // output register
  logic        out_v_r;
  rgba_t       out_px_r, out_px_nxt;
  logic [3:0]  out_idx_r;
  logic        out_last_r;

  logic [63:0] cw;
  logic [15:0] c0, c1;
  logic        out_free, emit, e_done;
  logic        s2_free, s2_load, s1_free, s1_load, s0_free, in_acc;

  // pipeline flow control
  assign out_free = !out_v_r || out_pix.ready;
  assign emit     = s2_v_r && out_free;
  assign e_done   = emit && (s2_cnt_r == LAST_PIX);
  assign s2_free  = !s2_v_r || e_done;
  assign s2_load  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_load;
  assign s1_load  = s0_v_r && s1_free;
  assign s0_free  = !s0_v_r || s1_load;
  assign in_acc   = in_blk.valid && s0_free;

  assign in_blk.ready = s0_free;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_BC1;
      s0_v_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      s2_cnt_r <= 4'd0;
    end else begin
      if (cfg_wr.valid) begin
        fmt_r <= cfg_wr.block_format;
      end
      if (s0_free) begin
        s0_v_r <= in_blk.valid;
      end
      if (s1_free) begin
        s1_v_r <= s0_v_r;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
      if (s2_load) begin
        s2_cnt_r <= 4'd0;
      end else if (emit) begin
        s2_cnt_r <= s2_cnt_r + 4'd1;
      end
    end
  end

  // stage 1: pick the color word, expand 565 endpoints, pick palette mode
  assign cw = (fmt_r == FMT_BC1) ? s0_lo_r : s0_hi_r;
  assign c0 = cw[15:0];
  assign c1 = cw[31:16];

  always_comb begin
    s1_ep0_nxt.r = expand5(c0[15:11]);
    s1_ep0_nxt.g = expand6(c0[10:5]);
    s1_ep0_nxt.b = expand5(c0[4:0]);
    s1_ep0_nxt.a = 8'hFF;
    s1_ep1_nxt.r = expand5(c1[15:11]);
    s1_ep1_nxt.g = expand6(c1[10:5]);
    s1_ep1_nxt.b = expand5(c1[4:0]);
    s1_ep1_nxt.a = 8'hFF;
    s1_three_nxt = (fmt_r == FMT_BC1) && (c0 <= c1);
  end

  // stage 2: color palette entries 2 and 3
  always_comb begin
    s2_cpal_nxt[0] = s1_ep0_r;
    s2_cpal_nxt[1] = s1_ep1_r;
    if (!s1_three_r) begin
      s2_cpal_nxt[2].r = div3(10'({s1_ep0_r.r, 1'b0}) + 10'(s1_ep1_r.r) + 10'd1);
      s2_cpal_nxt[2].g = div3(10'({s1_ep0_r.g, 1'b0}) + 10'(s1_ep1_r.g) + 10'd1);
      s2_cpal_nxt[2].b = div3(10'({s1_ep0_r.b, 1'b0}) + 10'(s1_ep1_r.b) + 10'd1);
      s2_cpal_nxt[2].a = 8'hFF;
      s2_cpal_nxt[3].r = div3(10'(s1_ep0_r.r) + 10'({s1_ep1_r.r, 1'b0}) + 10'd1);
      s2_cpal_nxt[3].g = div3(10'(s1_ep0_r.g) + 10'({s1_ep1_r.g, 1'b0}) + 10'd1);
      s2_cpal_nxt[3].b = div3(10'(s1_ep0_r.b) + 10'({s1_ep1_r.b, 1'b0}) + 10'd1);
      s2_cpal_nxt[3].a = 8'hFF;
    end else begin
      // three-color mode: midpoint, then transparent black
      s2_cpal_nxt[2].r = 8'((9'(s1_ep0_r.r) + 9'(s1_ep1_r.r) + 9'd1) >> 1);
      s2_cpal_nxt[2].g = 8'((9'(s1_ep0_r.g) + 9'(s1_ep1_r.g) + 9'd1) >> 1);
      s2_cpal_nxt[2].b = 8'((9'(s1_ep0_r.b) + 9'(s1_ep1_r.b) + 9'd1) >> 1);
      s2_cpal_nxt[2].a = 8'hFF;
      s2_cpal_nxt[3]   = '0;
    end
  end

  // stage 2: alpha palettes for both 8-byte halves
  bcn_alpha_pal u_apal_lo (
    .sums_i (s1_asum_lo_r),
    .pal_o  (s2_apal_lo_nxt)
  );

  bcn_alpha_pal u_apal_hi (
    .sums_i (s1_asum_hi_r),
    .pal_o  (s2_apal_hi_nxt)
  );

  // pixel assembly from the low selector bits
  always_comb begin
    rgba_t      cp;
    logic [7:0] al, ah;
    logic [3:0] ex;
    cp = s2_cpal_r[s2_csel_r[1:0]];
    al = s2_apal_lo_r[s2_asel_lo_r[2:0]];
    ah = s2_apal_hi_r[s2_asel_hi_r[2:0]];
    ex = s2_ex_r[3:0];
    case (fmt_r)
      FMT_BC1: begin
        out_px_nxt = cp;
      end
      FMT_BC2: begin
        out_px_nxt   = cp;
        out_px_nxt.a = {ex, ex};
      end
      FMT_BC3: begin
        out_px_nxt   = cp;
        out_px_nxt.a = al;
      end
      FMT_BC4: begin
        out_px_nxt = '{r: al, g: al, b: al, a: 8'hFF};
      end
      FMT_BC5: begin
        out_px_nxt = '{r: al, g: ah, b: 8'h00, a: 8'hFF};
      end
      default: begin
        out_px_nxt = '0;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_lo_r <= in_blk.block_low;
      s0_hi_r <= in_blk.block_high;
    end
    if (s1_load) begin
      s1_ep0_r     <= s1_ep0_nxt;
      s1_ep1_r     <= s1_ep1_nxt;
      s1_three_r   <= s1_three_nxt;
      s1_csel_r    <= cw[63:32];
      s1_asel_lo_r <= s0_lo_r[63:16];
      s1_asel_hi_r <= s0_hi_r[63:16];
      s1_ex_r      <= s0_lo_r;
      s1_asum_lo_r <= alpha_sums(s0_lo_r[7:0], s0_lo_r[15:8]);
      s1_asum_hi_r <= alpha_sums(s0_hi_r[7:0], s0_hi_r[15:8]);
    end
    if (s2_load) begin
      s2_cpal_r    <= s2_cpal_nxt;
      s2_apal_lo_r <= s2_apal_lo_nxt;
      s2_apal_hi_r <= s2_apal_hi_nxt;
      s2_csel_r    <= s1_csel_r;
      s2_asel_lo_r <= s1_asel_lo_r;
      s2_asel_hi_r <= s1_asel_hi_r;
      s2_ex_r      <= s1_ex_r;
    end else if (emit) begin
      s2_csel_r    <= s2_csel_r >> 2;
      s2_asel_lo_r <= s2_asel_lo_r >> 3;
      s2_asel_hi_r <= s2_asel_hi_r >> 3;
      s2_ex_r      <= s2_ex_r >> 4;
    end
    if (emit) begin
      out_px_r   <= out_px_nxt;
      out_idx_r  <= s2_cnt_r;
      out_last_r <= (s2_cnt_r == LAST_PIX);
    end
  end

  assign out_pix.valid       = out_v_r;
  assign out_pix.red         = out_px_r.r;
  assign out_pix.green       = out_px_r.g;
  assign out_pix.blue        = out_px_r.b;
  assign out_pix.alpha       = out_px_r.a;
  assign out_pix.pixel_index = out_idx_r;
  assign out_pix.last_pixel  = out_last_r;

endmodule

// ----- rtl/bcn_checker.sv -----
`timescale 1ns / 1ps

// Port-level checks on the pixel output channel.
module bcn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic [3:0] out_pixel_index,
  input logic       out_last_pixel
);

  // a stalled pixel word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_red, out_green, out_blue, out_alpha, out_pixel_index, out_last_pixel}))
    else $error("pixel word changed while stalled");

  // within a block pixels leave in raster order
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_pixel |=>
      !out_valid || (out_pixel_index == 4'($past(out_pixel_index) + 4'd1)))
    else $error("pixel index skipped");

  // a new block starts at pixel 0, and last_pixel marks pixel 15
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_pixel |=>
      !out_valid || (out_pixel_index == 4'd0))
    else $error("block did not restart at pixel 0");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_pixel_index == 4'd15)
    else $error("last_pixel on wrong index");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bcn_texture_block_decoder_unit bcn_checker u_bcn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_pix.valid),
  .out_ready       (out_pix.ready),
  .out_red         (out_pix.red),
  .out_green       (out_pix.green),
  .out_blue        (out_pix.blue),
  .out_alpha       (out_pix.alpha),
  .out_pixel_index (out_pix.pixel_index),
  .out_last_pixel  (out_pix.last_pixel)
);

// ----- verif/tb_bcn_texture_block_decoder_unit.sv -----
`timescale 1ns / 1ps

module tb_bcn_texture_block_decoder_unit;
  import bcn_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int QUIET_FROM   = 1200;   // window with no random idling on either side
  localparam int QUIET_TO     = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 24;     // settling margin after the last block drains
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BLOCKS = 26;

  // 3-bit selectors 0..7 twice over, for the alpha index field
  localparam logic [47:0] ALPHA_RAMP = 48'hFAC688FAC688;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
  } block_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] pixel_index;
    logic       last_pixel;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n;

  bcn_cfg_if cfg_wr();
  bcn_blk_if in_blk();
  bcn_pix_if out_pix();

  bcn_texture_block_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .in_blk (in_blk),
    .out_pix(out_pix)
  );

  block_word_t block_pending_q[$];
  pixel_word_t pixel_expect_q[$];
  logic [2:0]  fmt_shadow = FMT_BC1;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          hold_cycles_left = 0;
  logic        quiet;

  assign quiet = (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------------

  // 565 color to 8-bit channels {r, g, b}, truncating scale
  function automatic logic [23:0] expand_565(input logic [15:0] c);
    int unsigned r, g, b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    r = (r * 255) / 31;
    g = (g * 255) / 63;
    b = (b * 255) / 31;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  // weighted average with round-half-up
  function automatic logic [7:0] blend(input int unsigned a, input int unsigned b,
                                       input int unsigned wa, input int unsigned wb,
                                       input int unsigned d);
    int unsigned s;
    s = (a * wa + b * wb + d / 2) / d;
    return s[7:0];
  endfunction

  // color half of a block: 16 pixels as {r, g, b, a}
  function automatic logic [15:0][31:0] color_pixels(input logic [63:0] w,
                                                     input bit allow_three);
    logic [23:0]       e0, e1;
    logic [3:0][31:0]  pal;
    logic [15:0][31:0] px;
    bit                four_color;
    four_color = !allow_three || (w[15:0] > w[31:16]);
    e0 = expand_565(w[15:0]);
    e1 = expand_565(w[31:16]);
    pal[0] = {e0, 8'hFF};
    pal[1] = {e1, 8'hFF};
    for (int k = 0; k < 3; k++) begin
      if (four_color) begin
        pal[2][31-8*k -: 8] = blend(e0[23-8*k -: 8], e1[23-8*k -: 8], 2, 1, 3);
        pal[3][31-8*k -: 8] = blend(e0[23-8*k -: 8], e1[23-8*k -: 8], 1, 2, 3);
      end else begin
        pal[2][31-8*k -: 8] = blend(e0[23-8*k -: 8], e1[23-8*k -: 8], 1, 1, 2);
        pal[3][31-8*k -: 8] = 8'h00;
      end
    end
    pal[2][7:0] = 8'hFF;
    pal[3][7:0] = four_color ? 8'hFF : 8'h00;
    for (int i = 0; i < 16; i++) px[i] = pal[w[32+2*i +: 2]];
    return px;
  endfunction

  // interpolated 8-entry channel: 16 values
  function automatic logic [15:0][7:0] alpha_pixels(input logic [63:0] w);
    int unsigned      a0, a1, v;
    logic [7:0][7:0]  pal;
    logic [15:0][7:0] px;
    a0 = w[7:0];
    a1 = w[15:8];
    pal[0] = w[7:0];
    pal[1] = w[15:8];
    if (a0 > a1) begin
      for (int unsigned i = 1; i <= 6; i++) begin
        v = ((7 - i) * a0 + i * a1 + 3) / 7;
        pal[i+1] = v[7:0];
      end
    end else begin
      for (int unsigned i = 1; i <= 4; i++) begin
        v = ((5 - i) * a0 + i * a1 + 2) / 5;
        pal[i+1] = v[7:0];
      end
      pal[6] = 8'h00;
      pal[7] = 8'hFF;
    end
    for (int i = 0; i < 16; i++) px[i] = pal[w[16+3*i +: 3]];
    return px;
  endfunction

  // expected 16 pixels of one block under the current format
  task automatic predict_block(input logic [63:0] lo, input logic [63:0] hi);
    logic [15:0][31:0] rgba;
    logic [15:0][7:0]  ch_a, ch_b;
    pixel_word_t       px;
    rgba = '0;
    ch_a = alpha_pixels(lo);
    ch_b = alpha_pixels(hi);
    case (fmt_shadow)
      FMT_BC1: rgba = color_pixels(lo, 1'b1);
      FMT_BC2: begin
        rgba = color_pixels(hi, 1'b0);
        for (int i = 0; i < 16; i++) rgba[i][7:0] = 8'(lo[4*i +: 4]) * 8'd17;
      end
      FMT_BC3: begin
        rgba = color_pixels(hi, 1'b0);
        for (int i = 0; i < 16; i++) rgba[i][7:0] = ch_a[i];
      end
      FMT_BC4: begin
        for (int i = 0; i < 16; i++) rgba[i] = {ch_a[i], ch_a[i], ch_a[i], 8'hFF};
      end
      FMT_BC5: begin
        for (int i = 0; i < 16; i++) rgba[i] = {ch_a[i], ch_b[i], 8'h00, 8'hFF};
      end
      default: rgba = '0;  // undefined code: transparent black
    endcase
    for (int i = 0; i < 16; i++) begin
      px.red         = rgba[i][31:24];
      px.green       = rgba[i][23:16];
      px.blue        = rgba[i][15:8];
      px.alpha       = rgba[i][7:0];
      px.pixel_index = 4'(i);
      px.last_pixel  = (4'(i) == LAST_PIX);
      pixel_expect_q.push_back(px);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Block driver: offers the head of block_pending_q
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_blk.valid <= 1'b0;
    end else begin
      if (in_blk.valid && in_blk.ready) begin
        predict_block(in_blk.block_low, in_blk.block_high);
        void'(block_pending_q.pop_front());
      end
      // a word not yet taken stays on the bus
      if (!in_blk.valid || in_blk.ready) begin
        if (block_pending_q.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
          in_blk.valid      <= 1'b1;
          in_blk.block_low  <= block_pending_q[0].low;
          in_blk.block_high <= block_pending_q[0].high;
        end else begin
          in_blk.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel monitor and checker
  // ---------------------------------------------------------------------------
  task automatic check_pixel();
    pixel_word_t got, want;
    got = {out_pix.red, out_pix.green, out_pix.blue, out_pix.alpha,
           out_pix.pixel_index, out_pix.last_pixel};
    if (pixel_expect_q.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected pixel word: r=%h g=%h b=%h a=%h idx=%0d last=%b",
               $time, got.red, got.green, got.blue, got.alpha, got.pixel_index,
               got.last_pixel);
    end else begin
      want = pixel_expect_q.pop_front();
      if (got !== want) begin
        err_cnt++;
        $display("%0t: pixel mismatch: expected r=%h g=%h b=%h a=%h idx=%0d last=%b",
                 $time, want.red, want.green, want.blue, want.alpha, want.pixel_index,
                 want.last_pixel);
        $display("%0t:                 actual   r=%h g=%h b=%h a=%h idx=%0d last=%b",
                 $time, got.red, got.green, got.blue, got.alpha, got.pixel_index,
                 got.last_pixel);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pix.ready <= 1'b0;
    end else begin
      if (out_pix.valid && out_pix.ready) check_pixel();
      out_pix.ready <= (hold_cycles_left == 0) && (quiet || $urandom_range(99) >= 8);
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_cycles_left != 0) hold_cycles_left <= hold_cycles_left - 1;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_bcn_texture_block_decoder_unit: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_block(input logic [63:0] lo, input logic [63:0] hi);
    block_word_t b;
    b.low  = lo;
    b.high = hi;
    block_pending_q.push_back(b);
  endtask

  // returns at a falling edge once nothing is pending or outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (block_pending_q.size() != 0 || in_blk.valid || pixel_expect_q.size() != 0);
  endtask

  task automatic write_format(input logic [2:0] code);
    wait_drained();
    @(posedge clk);
    cfg_wr.valid        <= 1'b1;
    cfg_wr.block_format <= code;
    do @(posedge clk);
    while (!cfg_wr.ready);
    fmt_shadow = code;
    cfg_wr.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [2:0] code;
    rst_n               = 1'b0;
    in_blk.valid        = 1'b0;
    in_blk.block_low    = '0;
    in_blk.block_high   = '0;
    cfg_wr.valid        = 1'b0;
    cfg_wr.block_format = FMT_BC1;
    out_pix.ready       = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // BC1 from the reset format: zero, equal endpoints, both palette modes
    queue_block(64'h0, 64'h0);
    queue_block('1, '1);
    queue_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, rand64());
    queue_block({32'h1B1B1B1B, 16'hFFFF, 16'h0000}, rand64());

    // BC2: 4-bit alpha; color always four-entry even with c0 < c1
    write_format(FMT_BC2);
    queue_block(64'h0123456789ABCDEF, {32'hE4E4E4E4, 16'hF800, 16'h07E0});
    queue_block('1, '1);
    queue_block(64'h0, 64'h0);

    // BC3: alpha palette in both modes and with equal endpoints
    write_format(FMT_BC3);
    queue_block({ALPHA_RAMP, 8'h00, 8'hFF}, {32'hE4E4E4E4, 16'h001F, 16'hFFE0});
    queue_block({ALPHA_RAMP, 8'hFF, 8'h00}, rand64());
    queue_block({ALPHA_RAMP, 8'h80, 8'h80}, rand64());

    // BC4: grey, high half ignored
    write_format(FMT_BC4);
    queue_block({ALPHA_RAMP, 8'h10, 8'hF0}, rand64());
    queue_block({ALPHA_RAMP, 8'hF0, 8'h10}, rand64());

    // BC5: two channels, blue zero
    write_format(FMT_BC5);
    queue_block({ALPHA_RAMP, 8'h00, 8'hFF}, {ALPHA_RAMP, 8'hFF, 8'h00});
    queue_block('1, 64'h0);

    // undefined codes give transparent black
    write_format(3'd5);
    queue_block(rand64(), rand64());
    write_format(3'd7);
    queue_block('1, '1);

    // random phases, each under its own format
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) code = FMT_BC1;
      else if ($urandom_range(99) < 85) code = 3'($urandom_range(4));
      else code = 3'($urandom_range(7, 5));
      write_format(code);
      for (int n = 0; n < PHASE_BLOCKS; n++) queue_block(rand64(), rand64());
      // stall the receiver while the sender keeps offering blocks
      if (p == 2) begin
        @(posedge clk);
        hold_cycles_left <= HOLD_CYCLES;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0 && pixel_expect_q.size() == 0) begin
      $display("tb_bcn_texture_block_decoder_unit: done, clean");
    end else begin
      $display("tb_bcn_texture_block_decoder_unit: done, errors");
    end
    $finish;
  end

endmodule
